>>> hw/rtl/ray_box_slab_intersect_core_defines.svh
// assertion macros used by the checker file
// no dependencies; expects clk and rst_n in the scope of use
`ifndef RAY_BOX_SLAB_INTERSECT_CORE_DEFINES_SVH
`define RAY_BOX_SLAB_INTERSECT_CORE_DEFINES_SVH

// condition that holds at every clock edge outside reset
`define RBSI_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("rbsi check failed: lbl");

// condition that must hold in the cycle after the trigger
`define RBSI_ASSERT_NEXT(lbl, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("rbsi check failed: lbl");

`endif

>>> hw/rtl/rbsi_pkg.sv
// shared types and constants of the ray box slab intersect block
// no dependencies
package rbsi_pkg;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_BOX_MIN_X = 3'd0,
        CFG_BOX_MIN_Y = 3'd1,
        CFG_BOX_MIN_Z = 3'd2,
        CFG_BOX_MAX_X = 3'd3,
        CFG_BOX_MAX_Y = 3'd4,
        CFG_BOX_MAX_Z = 3'd5
    } cfg_index_t;

    localparam int NUM_AXES = 3;

endpackage

>>> hw/rtl/ray_box_slab_intersect_core.sv
// top level of the ray box slab intersect block: pipelined slab test
// depends on rbsi_pkg
//
// channel   direction  handshake                 contents
// s_axis    in         s_axis_tvalid/tready      origin xyz, dir xyz, best_time
// m_axis    out        m_axis_tvalid/tready      hit, new_time
// cfg       in         cfg_valid/cfg_ready       cfg_index, cfg_data (box corners)
//
// one item per cycle while m_axis does not stall; the reciprocal divider
// works bit per stage, one stage per quotient bit
// rst_n clears the valid chain and the box registers
// a stall on m_axis freezes the whole pipeline and holds s_axis_tready low
module ray_box_slab_intersect_core
    import rbsi_pkg::*;
#(
    parameter int COORD_WIDTH   = 32,
    parameter int FRACTION_BITS = 16
)
(
    input  logic clk,
    input  logic rst_n,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, best_time, zero pad
    input  logic [((7*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // hit, new_time, zero pad
    output logic [((1+COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [COORD_WIDTH-1:0] cfg_data
);

    localparam int W     = COORD_WIDTH;
    localparam int F     = FRACTION_BITS;
    localparam int QB    = 2*F + 1;
    localparam int QW    = ((QB > W) ? QB : W) + 1;
    localparam int OUT_W = ((1+W+7)/8)*8;
    localparam int PW    = 2*W + 1;

    localparam logic [QW-1:0] QMAX   = QW'({1'b0, {(W-1){1'b1}}});
    localparam logic [QW-1:0] QMINMG = QW'(1) << (W-1);
    localparam logic signed [PW-1:0] PMAX = PW'($signed({1'b0, {(W-1){1'b1}}}));
    localparam logic signed [PW-1:0] PMIN = -PMAX - PW'(1);

    // saturate a floored product to the coordinate range
    function automatic logic [W-1:0] sat_prod(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] s;
        s = p >>> F;
        if (s > PMAX)
            return {1'b0, {(W-1){1'b1}}};
        else if (s < PMIN)
            return {1'b1, {(W-1){1'b0}}};
        else
            return s[W-1:0];
    endfunction

    // sign and saturate the unsigned quotient to a reciprocal
    function automatic logic [W-1:0] sat_recip(input logic [QB-1:0] q,
                                               input logic neg, input logic zero);
        logic [QW-1:0] qx;
        logic [QW-1:0] nq;
        qx = QW'(q);
        nq = -qx;
        if (zero)
            return {1'b1, {(W-1){1'b0}}};
        else if (!neg)
            return (qx > QMAX) ? QMAX[W-1:0] : qx[W-1:0];
        else
            return (qx > QMINMG) ? {1'b1, {(W-1){1'b0}}} : nq[W-1:0];
    endfunction

    logic en;

    // box registers
    logic [W-1:0] box_min_reg [0:NUM_AXES-1];
    logic [W-1:0] box_max_reg [0:NUM_AXES-1];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                box_min_reg[i] <= '0;
                box_max_reg[i] <= '0;
            end
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_BOX_MIN_X: box_min_reg[0] <= cfg_data;
                CFG_BOX_MIN_Y: box_min_reg[1] <= cfg_data;
                CFG_BOX_MIN_Z: box_min_reg[2] <= cfg_data;
                CFG_BOX_MAX_X: box_max_reg[0] <= cfg_data;
                CFG_BOX_MAX_Y: box_max_reg[1] <= cfg_data;
                CFG_BOX_MAX_Z: box_max_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // divider pipeline: index 0 is the input stage, index k+1 follows step k
    logic            v_reg      [0:QB];
    logic [W-1:0]    best_reg   [0:QB];
    logic [W-1:0]    rem_reg    [0:QB][0:NUM_AXES-1];
    logic [QB-1:0]   quot_reg   [0:QB][0:NUM_AXES-1];
    logic [W-1:0]    dmag_reg   [0:QB][0:NUM_AXES-1];
    logic            ddneg_reg  [0:QB][0:NUM_AXES-1];
    logic            ddzero_reg [0:QB][0:NUM_AXES-1];
    logic            dirneg_reg [0:QB][0:NUM_AXES-1];
    logic [W:0]      dlo_reg    [0:QB][0:NUM_AXES-1];
    logic [W:0]      dhi_reg    [0:QB][0:NUM_AXES-1];

    // later stages
    logic            v1_reg, v2_reg, v3_reg, vo_reg;
    logic [W-1:0]    best1_reg, best2_reg, best3_reg;
    logic [W-1:0]    recip_reg  [0:NUM_AXES-1];
    logic            dn1_reg    [0:NUM_AXES-1];
    logic            dn2_reg    [0:NUM_AXES-1];
    logic [W:0]      dlo1_reg   [0:NUM_AXES-1];
    logic [W:0]      dhi1_reg   [0:NUM_AXES-1];
    logic [PW-1:0]   plo_reg    [0:NUM_AXES-1];
    logic [PW-1:0]   phi_reg    [0:NUM_AXES-1];
    logic [W-1:0]    tin_reg    [0:NUM_AXES-1];
    logic [W-1:0]    tout_reg   [0:NUM_AXES-1];
    logic            hit_reg;
    logic [W-1:0]    time_reg;

    // whole pipeline moves unless the output item is stalled
    assign en            = m_axis_tready || !vo_reg;
    assign s_axis_tready = en;

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= QB; k++)
                v_reg[k] <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= s_axis_tvalid;
            for (int k = 0; k < QB; k++)
                v_reg[k+1] <= v_reg[k];
            v1_reg <= v_reg[QB];
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            vo_reg <= v3_reg;
        end
    end

    // input stage: biased direction, its magnitude, slab distances
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            best_reg[0] <= s_axis_tdata[6*W +: W];
            for (int a = 0; a < NUM_AXES; a++)
            begin
                logic [W:0] dd;
                logic [W:0] ddm;
                logic [W:0] org;
                dd  = {s_axis_tdata[(3+a)*W + W-1], s_axis_tdata[(3+a)*W +: W]}
                      + (W+1)'(1);
                ddm = dd[W] ? -dd : dd;
                org = {s_axis_tdata[a*W + W-1], s_axis_tdata[a*W +: W]};
                rem_reg[0][a]    <= '0;
                quot_reg[0][a]   <= '0;
                dmag_reg[0][a]   <= ddm[W-1:0];
                ddneg_reg[0][a]  <= dd[W];
                ddzero_reg[0][a] <= (dd == '0);
                dirneg_reg[0][a] <= s_axis_tdata[(3+a)*W + W-1];
                dlo_reg[0][a]    <= {box_min_reg[a][W-1], box_min_reg[a]} - org;
                dhi_reg[0][a]    <= {box_max_reg[a][W-1], box_max_reg[a]} - org;
            end
        end
    end

    // one restoring divide step per stage, dividend 2^(2F)
    for (genvar k = 0; k < QB; k++)
    begin : g_div
        localparam logic INB = (k == 0);
        for (genvar a = 0; a < NUM_AXES; a++)
        begin : g_axis
            logic [W:0] trial;
            logic [W:0] diff;
            logic       ge;
            assign trial = {rem_reg[k][a], INB};
            assign diff  = trial - {1'b0, dmag_reg[k][a]};
            assign ge    = (trial >= {1'b0, dmag_reg[k][a]});

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k+1][a]    <= ge ? diff[W-1:0] : trial[W-1:0];
                    quot_reg[k+1][a]   <= {quot_reg[k][a][QB-2:0], ge};
                    dmag_reg[k+1][a]   <= dmag_reg[k][a];
                    ddneg_reg[k+1][a]  <= ddneg_reg[k][a];
                    ddzero_reg[k+1][a] <= ddzero_reg[k][a];
                    dirneg_reg[k+1][a] <= dirneg_reg[k][a];
                    dlo_reg[k+1][a]    <= dlo_reg[k][a];
                    dhi_reg[k+1][a]    <= dhi_reg[k][a];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
                best_reg[k+1] <= best_reg[k];
        end
    end

    // reciprocal sign and saturation, then slab products, then crossing times
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            best1_reg <= best_reg[QB];
            best2_reg <= best1_reg;
            best3_reg <= best2_reg;
            for (int a = 0; a < NUM_AXES; a++)
            begin
                recip_reg[a] <= sat_recip(quot_reg[QB][a], ddneg_reg[QB][a],
                                          ddzero_reg[QB][a]);
                dn1_reg[a]   <= dirneg_reg[QB][a];
                dlo1_reg[a]  <= dlo_reg[QB][a];
                dhi1_reg[a]  <= dhi_reg[QB][a];

                plo_reg[a]   <= $signed(dlo1_reg[a]) * $signed(recip_reg[a]);
                phi_reg[a]   <= $signed(dhi1_reg[a]) * $signed(recip_reg[a]);
                dn2_reg[a]   <= dn1_reg[a];

                tin_reg[a]   <= dn2_reg[a] ? sat_prod($signed(phi_reg[a]))
                                           : sat_prod($signed(plo_reg[a]));
                tout_reg[a]  <= dn2_reg[a] ? sat_prod($signed(plo_reg[a]))
                                           : sat_prod($signed(phi_reg[a]));
            end
        end
    end

    // latest entry, earliest exit and the hit decision
    logic signed [W-1:0] lower;
    logic signed [W-1:0] upper;
    logic                hit;

    always_comb
    begin
        lower = $signed(tin_reg[0]);
        upper = $signed(tout_reg[0]);
        for (int a = 1; a < NUM_AXES; a++)
        begin
            if ($signed(tin_reg[a]) > lower)
                lower = $signed(tin_reg[a]);
            if ($signed(tout_reg[a]) < upper)
                upper = $signed(tout_reg[a]);
        end
        hit = (lower <= upper) && ($signed(best3_reg) > lower);
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg  <= hit;
            time_reg <= hit ? lower : best3_reg;
        end
    end

    assign m_axis_tvalid = vo_reg;
    assign m_axis_tdata  = OUT_W'({time_reg, hit_reg});

endmodule

>>> hw/rtl/rbsi_checker.sv
// port-level checks of ray_box_slab_intersect_core, bound to the top level
// depends on ray_box_slab_intersect_core_defines.svh
`include "ray_box_slab_intersect_core_defines.svh"

module rbsi_checker
#(
    parameter int COORD_WIDTH = 32
)
(
    input logic clk,
    input logic rst_n,
    input logic s_axis_tvalid,
    input logic s_axis_tready,
    input logic [((1+COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic cfg_valid,
    input logic cfg_ready
);

    // a stalled result item holds its value
    `RBSI_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // input side is open exactly when the output stage can move
    `RBSI_ASSERT_ALWAYS(a_ready_link, s_axis_tready == (m_axis_tready || !m_axis_tvalid))

    // configuration writes never wait
    `RBSI_ASSERT_ALWAYS(a_cfg_open, cfg_ready || !cfg_valid)

endmodule

bind ray_box_slab_intersect_core rbsi_checker #(.COORD_WIDTH(COORD_WIDTH)) u_rbsi_checker (.*);

>>> verif/tb_top.sv
// testbench of ray_box_slab_intersect_core: random and directed rays against boxes
// depends on rbsi_pkg and the core; a scoreboard class holds predicted results
`timescale 1ns / 1ps

class slab_scoreboard;
    logic [32:0] pending_results[$];
    logic signed [31:0] box_lo[3];
    logic signed [31:0] box_hi[3];
    int errors;

    function new();
        errors = 0;
        for (int a = 0; a < 3; a++)
        begin
            box_lo[a] = 0;
            box_hi[a] = 0;
        end
    endfunction

    // saturate a wide value to the signed 32-bit range
    function automatic logic signed [31:0] clamp32(logic signed [127:0] v);
        if (v > 128'sd2147483647)
            return 32'sh7fffffff;
        if (v < -128'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    // reciprocal of the biased direction, q16.16
    function automatic logic signed [31:0] recip(logic signed [31:0] d);
        logic signed [127:0] dd;
        logic signed [127:0] q;
        dd = 128'(d) + 1;
        if (dd == 0)
            return 32'sh80000000;
        q = (128'sd1 <<< 32) / dd;
        return clamp32(q);
    endfunction

    // fixed multiply with floor shift and saturation
    function automatic logic signed [31:0] fmul(logic signed [127:0] a,
                                                logic signed [31:0] b);
        logic signed [127:0] p;
        p = a * 128'(b);
        return clamp32(p >>> 16);
    endfunction

    function automatic void note_ray(logic [223:0] ray);
        logic signed [31:0] org;
        logic signed [31:0] dir;
        logic signed [31:0] best;
        logic signed [31:0] r;
        logic signed [31:0] ta;
        logic signed [31:0] tb;
        logic signed [31:0] t_enter;
        logic signed [31:0] t_leave;
        logic hit;
        best = ray[223:192];
        t_enter = 32'sh80000000;
        t_leave = 32'sh7fffffff;
        for (int a = 0; a < 3; a++)
        begin
            org = ray[32*a +: 32];
            dir = ray[96 + 32*a +: 32];
            r = recip(dir);
            ta = fmul(128'(box_lo[a]) - 128'(org), r);
            tb = fmul(128'(box_hi[a]) - 128'(org), r);
            if (dir < 0)
            begin
                ta = ta ^ tb;
                tb = ta ^ tb;
                ta = ta ^ tb;
            end
            if (a == 0 || ta > t_enter)
                t_enter = ta;
            if (a == 0 || tb < t_leave)
                t_leave = tb;
        end
        hit = (t_enter <= t_leave) && (best > t_enter);
        pending_results.push_back({hit ? t_enter : best, hit});
    endfunction

    function automatic void check_result(logic [39:0] data);
        logic [32:0] want;
        if (pending_results.size() == 0)
        begin
            $error("unexpected result item %h", data);
            errors++;
            return;
        end
        want = pending_results.pop_front();
        if (data[0] !== want[0])
        begin
            $error("hit: expected %0d actual %0d", want[0], data[0]);
            errors++;
        end
        if (data[32:1] !== want[32:1])
        begin
            $error("new_time: expected %h actual %h", want[32:1], data[32:1]);
            errors++;
        end
        if (data[39:33] !== 7'd0)
        begin
            $error("pad: expected 0 actual %h", data[39:33]);
            errors++;
        end
    endfunction
endclass

module tb_top;
    import rbsi_pkg::*;

    logic clk = 0;
    logic rst_n = 0;
    logic [223:0] s_axis_tdata = '0;
    logic s_axis_tvalid = 0;
    logic s_axis_tready;
    logic [39:0] m_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready = 0;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    slab_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cycle_count = 0;

    localparam int PIPE_CYCLES = 38;
    localparam int CYCLE_LIMIT = 400000;

    ray_box_slab_intersect_core uut (.*);

    always #5 clk = ~clk;

    // result side: random stall, check on accepted items
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    always @(negedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic write_box(cfg_index_t idx, logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx <= CFG_BOX_MIN_Z)
            sb.box_lo[idx] = val;
        else
            sb.box_hi[idx - 3] = val;
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    // entered at a falling edge; ends the burst and waits for all results
    task automatic drain();
        s_axis_tvalid <= 0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (PIPE_CYCLES + 4) @(posedge clk);
    endtask

    // entered at a falling edge; valid stays high so items can follow back to back
    task automatic send_ray(logic [223:0] ray);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 0;
            @(negedge clk);
        end
        s_axis_tdata <= ray;
        s_axis_tvalid <= 1;
        do @(posedge clk); while (!s_axis_tready);
        sb.note_ray(ray);
        @(negedge clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(5))
            0: return $urandom;
            1: return {$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom)};
            2: return 32'($signed($urandom_range(40)) - 20) <<< 16;
            3: return 32'($signed($urandom_range(8)) - 4);
            4: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
            default: return 32'($signed($urandom_range(2000)) - 1000) <<< 10;
        endcase
    endfunction

    function automatic logic [223:0] rand_ray();
        logic [223:0] r;
        for (int f = 0; f < 7; f++)
            r[32*f +: 32] = rand_coord();
        return r;
    endfunction

    task automatic random_box();
        logic signed [31:0] lo;
        for (int a = 0; a < 3; a++)
        begin
            lo = rand_coord();
            write_box(cfg_index_t'(a), lo);
            if ($urandom_range(7) == 0)
                write_box(cfg_index_t'(a + 3), rand_coord());
            else
                write_box(cfg_index_t'(a + 3), lo + 32'($urandom_range(32'h000fffff)));
        end
    endtask

    // directed rays: zero and minus-one directions, extremes, inside origin, inverted box
    task automatic directed_rays();
        logic [31:0] dvals[6] = '{32'h0, 32'hffffffff, 32'h7fffffff, 32'h80000000,
                                  32'h00010000, 32'hffff0000};
        logic [223:0] r;
        write_box(CFG_BOX_MIN_X, 32'hfffe0000);
        write_box(CFG_BOX_MIN_Y, 32'hfffe0000);
        write_box(CFG_BOX_MIN_Z, 32'hfffe0000);
        write_box(CFG_BOX_MAX_X, 32'h00020000);
        write_box(CFG_BOX_MAX_Y, 32'h00020000);
        write_box(CFG_BOX_MAX_Z, 32'h00020000);
        for (int i = 0; i < 6; i++)
        begin
            r = '0;
            r[31:0] = 32'hfff60000;
            r[127:96] = dvals[i];
            r[159:128] = dvals[(i + 1) % 6];
            r[191:160] = dvals[(i + 2) % 6];
            r[223:192] = 32'h7fffffff;
            send_ray(r);
        end
        // origin inside the box, and a best time that blocks the hit
        send_ray({32'h7fffffff, 32'h0, 32'h0, 32'h00010000, 96'h0});
        send_ray({32'h80000000, 32'h0, 32'h0, 32'h00010000, 96'h0});
        send_ray({32'h7fffffff, 96'h0, {3{32'h80000000}}});
        send_ray({32'h80000000, 96'hffffffff_ffffffff_ffffffff, {3{32'h7fffffff}}});
        send_ray('1);
        drain();
        // inverted box at the register extremes, then the full-range box
        write_box(CFG_BOX_MIN_X, 32'h7fffffff);
        write_box(CFG_BOX_MAX_X, 32'h80000000);
        for (int i = 0; i < 4; i++)
            send_ray(rand_ray());
        drain();
        write_box(CFG_BOX_MIN_X, 32'h80000000);
        write_box(CFG_BOX_MAX_X, 32'h7fffffff);
        for (int i = 0; i < 4; i++)
            send_ray(rand_ray());
        drain();
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;
        directed_rays();
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 26 : (phase == 1) ? 81 : 0;
            recv_idle_pct = (phase == 0) ? 81 : (phase == 1) ? 26 : 0;
            for (int blk = 0; blk < 7; blk++)
            begin
                random_box();
                for (int i = 0; i < 50; i++)
                begin
                    // sender pauses until every expected result is back
                    if (i == 25 && blk == 0)
                    begin
                        s_axis_tvalid <= 0;
                        while (sb.pending_results.size() != 0)
                            @(posedge clk);
                        @(negedge clk);
                    end
                    send_ray(rand_ray());
                end
                drain();
            end
        end
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
